[hdl/ets_pkg.sv]
package ets_pkg;

  // Chip geometry
  localparam int unsigned PAGE_BYTES  = 16;
  localparam int unsigned BLOCK_BYTES = 256;
  localparam int unsigned BLOCK_COUNT = 4;
  localparam int unsigned MAX_RESULTS = 64;

  localparam int unsigned ADDR_W  = 10;
  localparam int unsigned LEN_W   = 11;
  localparam int unsigned SEG_W   = 9;
  localparam int unsigned OFF_W   = $clog2(BLOCK_BYTES);
  localparam int unsigned PAGE_SH = $clog2(PAGE_BYTES);
  localparam int unsigned CNT_W   = $clog2(MAX_RESULTS);

  localparam logic [LEN_W-1:0] CHIP_BYTES = LEN_W'(BLOCK_BYTES * BLOCK_COUNT);
  localparam logic [7:0]       DEV_BASE   = 8'hA0;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_READ  = 1'b1;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  // Datapath controls driven from the current control word
  typedef struct packed {
    logic load;
    logic clamp;
    logic count;
    logic emit_seg;
    logic emit_err;
  } ets_ctrl_t;

  // Datapath conditions tested by jumps
  typedef struct packed {
    logic err;
    logic done;
  } ets_flags_t;

endpackage

[hdl/eeprom_transfer_segmenter.sv]
// Steps to the first word: CHECK, CLAMP, COUNT, SEG (CHECK, ERR for an error word).
// busy stays high from the CHECK step through the last segment; one word per cycle
//   while segments stream, set by the single-step emit loop of the control program.
// Reset: rst_ni clears the step counter and the strobe; the A2 pin level resets to 1.
// The receiver cannot stall: each word is shown for exactly one cycle.
module eeprom_transfer_segmenter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Request channel
  input  logic                       start,
  output logic                       busy,
  input  logic                       command_i,
  input  logic [ets_pkg::ADDR_W-1:0] start_address_i,
  input  logic [ets_pkg::LEN_W-1:0]  transfer_length_i,
  // Configuration channel: A2 pin level
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic                       cfg_data_i,
  // Result words
  output logic                       result_valid_o,
  output logic [7:0]                 device_select_o,
  output logic [7:0]                 word_address_o,
  output logic [ets_pkg::SEG_W-1:0]  segment_length_o,
  output logic                       status_o,
  output logic                       truncated_o,
  output logic                       last_segment_o
);
  import ets_pkg::*;

  ets_ctrl_t  ctrl;
  ets_flags_t flags;
  logic       a2_q;

  // Configuration must be written only while idle; the block does not enforce it, so always take it.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a2_q <= 1'b1;
    end else if (cfg_valid_i && cfg_ready_o) begin
      a2_q <= cfg_data_i;
    end
  end

  // Control program: idle/load, check for an empty or out-of-range
  // request, clamp at the chip end, count segments to flag overflow,
  // then emit one segment per step until the last one, or one error word.
  ets_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .flags_i (flags),
    .ctrl_o  (ctrl),
    .busy_o  (busy)
  );

  // Address/remaining-length registers, segment cut logic and the
  // registered result word.
  ets_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .ctrl_i            (ctrl),
    .a2_i              (a2_q),
    .command_i         (command_i),
    .start_address_i   (start_address_i),
    .transfer_length_i (transfer_length_i),
    .flags_o           (flags),
    .result_valid_o    (result_valid_o),
    .device_select_o   (device_select_o),
    .word_address_o    (word_address_o),
    .segment_length_o  (segment_length_o),
    .status_o          (status_o),
    .truncated_o       (truncated_o),
    .last_segment_o    (last_segment_o)
  );

endmodule

[hdl/ets_seq.sv]
module ets_seq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  ets_pkg::ets_flags_t flags_i,
  output ets_pkg::ets_ctrl_t  ctrl_o,
  output logic                busy_o
);
  import ets_pkg::*;

  typedef enum logic [1:0] {
    COND_ALWAYS = 2'd0,
    COND_START  = 2'd1,
    COND_ERR    = 2'd2,
    COND_DONE   = 2'd3
  } cond_e;

  typedef struct packed {
    logic      busy;
    ets_ctrl_t ctrl;
    cond_e     cond;
    logic [2:0] jump;
    logic [2:0] next;
  } uop_t;

  localparam logic [2:0] STEP_IDLE  = 3'd0;
  localparam logic [2:0] STEP_CHECK = 3'd1;
  localparam logic [2:0] STEP_CLAMP = 3'd2;
  localparam logic [2:0] STEP_COUNT = 3'd3;
  localparam logic [2:0] STEP_SEG   = 3'd4;
  localparam logic [2:0] STEP_ERR   = 3'd5;

  // ctrl order: load, clamp, count, emit_seg, emit_err
  function automatic uop_t ucode(input logic [2:0] step);
    uop_t u;
    case (step)
      STEP_IDLE:  u = '{1'b0, '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0}, COND_START,
                        STEP_CHECK, STEP_IDLE};
      STEP_CHECK: u = '{1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, COND_ERR,
                        STEP_ERR, STEP_CLAMP};
      STEP_CLAMP: u = '{1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0}, COND_ALWAYS,
                        STEP_COUNT, STEP_COUNT};
      STEP_COUNT: u = '{1'b1, '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0}, COND_ALWAYS,
                        STEP_SEG, STEP_SEG};
      STEP_SEG:   u = '{1'b1, '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0}, COND_DONE,
                        STEP_IDLE, STEP_SEG};
      STEP_ERR:   u = '{1'b1, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1}, COND_ALWAYS,
                        STEP_IDLE, STEP_IDLE};
      default:    u = '{1'b0, '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0}, COND_ALWAYS,
                        STEP_IDLE, STEP_IDLE};
    endcase
    return u;
  endfunction

  logic [2:0] step_q, step_d;
  uop_t       uop;
  logic       take;

  assign uop = ucode(step_q);

  always_comb begin
    case (uop.cond)
      COND_ALWAYS: take = 1'b1;
      COND_START:  take = start_i;
      COND_ERR:    take = flags_i.err;
      COND_DONE:   take = flags_i.done;
      default:     take = 1'b1;
    endcase
    step_d = take ? uop.jump : uop.next;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = uop.ctrl;
  assign busy_o = uop.busy;

endmodule

[hdl/ets_dp.sv]
module ets_dp (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ets_pkg::ets_ctrl_t         ctrl_i,
  input  logic                       a2_i,
  input  logic                       command_i,
  input  logic [ets_pkg::ADDR_W-1:0] start_address_i,
  input  logic [ets_pkg::LEN_W-1:0]  transfer_length_i,
  output ets_pkg::ets_flags_t        flags_o,
  output logic                       result_valid_o,
  output logic [7:0]                 device_select_o,
  output logic [7:0]                 word_address_o,
  output logic [ets_pkg::SEG_W-1:0]  segment_length_o,
  output logic                       status_o,
  output logic                       truncated_o,
  output logic                       last_segment_o
);
  import ets_pkg::*;

  localparam logic [OFF_W-1:0] PAGE_MASK = OFF_W'(PAGE_BYTES - 1);

  logic              cmd_q;
  logic [ADDR_W-1:0] addr_q;
  logic [LEN_W-1:0]  rem_q;
  logic              trunc_q;
  logic [CNT_W-1:0]  cnt_q;

  logic              valid_q;
  logic [7:0]        ds_q, wa_q;
  logic [SEG_W-1:0]  len_q;
  logic              st_q, tr_q, last_q;

  logic [LEN_W-1:0]  addr_ext, chip_room, end_addr, unit_first, unit_last, unit_diff;
  logic [OFF_W-1:0]  off;
  logic [SEG_W-1:0]  blk_room, page_room, room, seg;
  logic [7:0]        dev_sel;
  logic              seg_last;

  assign addr_ext  = {1'b0, addr_q};
  assign chip_room = CHIP_BYTES - addr_ext;
  assign end_addr  = addr_ext + rem_q - LEN_W'(1);
  assign off       = addr_q[OFF_W-1:0];
  assign dev_sel   = DEV_BASE | {4'b0000, a2_i, addr_q[ADDR_W-1 -: 2], 1'b0};

  // Segment units touched: pages for writes, blocks for reads
  always_comb begin
    if (cmd_q == CMD_READ) begin
      unit_first = addr_ext >> OFF_W;
      unit_last  = end_addr >> OFF_W;
    end else begin
      unit_first = addr_ext >> PAGE_SH;
      unit_last  = end_addr >> PAGE_SH;
    end
    unit_diff = unit_last - unit_first;
  end

  always_comb begin
    blk_room  = SEG_W'(BLOCK_BYTES) - {1'b0, off};
    page_room = SEG_W'(PAGE_BYTES) - {1'b0, off & PAGE_MASK};
    room      = (cmd_q == CMD_WRITE && page_room < blk_room) ? page_room : blk_room;
    seg       = ({{(LEN_W-SEG_W){1'b0}}, room} < rem_q) ? room : rem_q[SEG_W-1:0];
    seg_last  = (rem_q == {{(LEN_W-SEG_W){1'b0}}, seg}) ||
                (cnt_q == CNT_W'(MAX_RESULTS - 1));
  end

  assign flags_o.err  = (rem_q == '0) || (addr_ext >= CHIP_BYTES);
  assign flags_o.done = seg_last;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= command_i;
      addr_q  <= start_address_i;
      rem_q   <= transfer_length_i;
      trunc_q <= 1'b0;
      cnt_q   <= '0;
    end
    if (ctrl_i.clamp && rem_q > chip_room) begin
      rem_q   <= chip_room;
      trunc_q <= 1'b1;
    end
    if (ctrl_i.count && unit_diff >= LEN_W'(MAX_RESULTS)) begin
      trunc_q <= 1'b1;
    end
    if (ctrl_i.emit_seg) begin
      addr_q <= addr_q + {{(ADDR_W-SEG_W){1'b0}}, seg};
      rem_q  <= rem_q - {{(LEN_W-SEG_W){1'b0}}, seg};
      cnt_q  <= cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= ctrl_i.emit_seg | ctrl_i.emit_err;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.emit_seg) begin
      ds_q   <= dev_sel;
      wa_q   <= off;
      len_q  <= seg;
      st_q   <= STATUS_OK;
      tr_q   <= trunc_q;
      last_q <= seg_last;
    end else if (ctrl_i.emit_err) begin
      ds_q   <= dev_sel;
      wa_q   <= off;
      len_q  <= '0;
      st_q   <= STATUS_EMPTY;
      tr_q   <= (rem_q != '0);
      last_q <= 1'b1;
    end
  end

  assign result_valid_o   = valid_q;
  assign device_select_o  = ds_q;
  assign word_address_o   = wa_q;
  assign segment_length_o = len_q;
  assign status_o         = st_q;
  assign truncated_o      = tr_q;
  assign last_segment_o   = last_q;

endmodule

[hdl/ets_checker.sv]
module ets_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       start,
  input logic                       busy,
  input logic                       result_valid_o,
  input logic [ets_pkg::SEG_W-1:0]  segment_length_o,
  input logic                       status_o,
  input logic                       last_segment_o
);
  import ets_pkg::*;

  // Segments of one request stream without gaps
  a_stream: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_segment_o |=> result_valid_o)
    else $error("gap inside a segment stream");

  // While the final word shows, the block is already free again
  a_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && last_segment_o |-> !busy)
    else $error("busy after final word");

  // A rejected request is a single empty word
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == STATUS_EMPTY |->
      segment_length_o == '0 && last_segment_o)
    else $error("malformed error word");

  a_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && status_o == STATUS_OK |-> segment_length_o != '0)
    else $error("empty segment reported ok");

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted request not worked on");

endmodule

bind eeprom_transfer_segmenter ets_checker u_ets_checker (.*);

[tb/eeprom_transfer_segmenter_test.sv]
module eeprom_transfer_segmenter_test;
  timeunit 1ns;
  timeprecision 1ps;

  import ets_pkg::*;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned QUIET_LIMIT  = 5000;  // cycles with no handshake at all
  localparam int unsigned TAIL_CYCLES  = 12;    // tail after the final drain to catch stray words
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned RAND_PHASES  = 4;
  localparam int unsigned PHASE_ITEMS  = 105;   // 4 phases, about 420 random requests
  localparam int unsigned NUM_DIRECTED = 23;

  // One result word as the segmenter shows it on its output ports
  typedef struct packed {
    logic [7:0]       dsel;
    logic [7:0]       waddr;
    logic [SEG_W-1:0] seg_len;
    logic             status;
    logic             trunc;
    logic             last;
  } xfer_word_t;

  // One directed request; fixed_word is used only for single-word rows marked known
  typedef struct packed {
    logic             cmd;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic             known;
    xfer_word_t       fixed_word;
  } request_row_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              req_start = 1'b0;
  logic              req_busy;
  logic              req_cmd = CMD_WRITE;
  logic [ADDR_W-1:0] req_addr = '0;
  logic [LEN_W-1:0]  req_len = '0;
  logic              a2_valid = 1'b0;
  logic              a2_ready;
  logic              a2_data = 1'b0;
  logic              word_strobe;
  logic [7:0]        word_dsel;
  logic [7:0]        word_waddr;
  logic [SEG_W-1:0]  word_len;
  logic              word_status;
  logic              word_trunc;
  logic              word_last;

  // Predictor state: the A2 level the block should be using right now
  logic              a2_level = 1'b1;
  xfer_word_t        expected_words[$];

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned requests_sent = 0;
  int unsigned words_seen = 0;
  int unsigned rejected_words = 0;
  int unsigned truncated_words = 0;
  int unsigned a2_writes = 0;

  // Directed rows run right after reset, so A2 is still at its reset level of 1.
  // Known rows carry the single word that can be read straight off the spec.
  request_row_t directed_rows [NUM_DIRECTED] = '{
    // empty requests at both address extremes and mid-chip
    '{CMD_WRITE, 10'd0,    11'd0,    1'b1, '{8'hA8, 8'h00, 9'd0,   STATUS_EMPTY, 1'b0, 1'b1}},
    '{CMD_READ,  10'd1023, 11'd0,    1'b1, '{8'hAE, 8'hFF, 9'd0,   STATUS_EMPTY, 1'b0, 1'b1}},
    '{CMD_READ,  10'd512,  11'd0,    1'b1, '{8'hAC, 8'h00, 9'd0,   STATUS_EMPTY, 1'b0, 1'b1}},
    // smallest and largest single segments
    '{CMD_WRITE, 10'd0,    11'd1,    1'b1, '{8'hA8, 8'h00, 9'd1,   STATUS_OK,    1'b0, 1'b1}},
    '{CMD_READ,  10'd0,    11'd256,  1'b1, '{8'hA8, 8'h00, 9'd256, STATUS_OK,    1'b0, 1'b1}},
    '{CMD_READ,  10'd256,  11'd256,  1'b1, '{8'hAA, 8'h00, 9'd256, STATUS_OK,    1'b0, 1'b1}},
    '{CMD_READ,  10'd768,  11'd256,  1'b1, '{8'hAE, 8'h00, 9'd256, STATUS_OK,    1'b0, 1'b1}},
    '{CMD_READ,  10'd1023, 11'd1,    1'b1, '{8'hAE, 8'hFF, 9'd1,   STATUS_OK,    1'b0, 1'b1}},
    '{CMD_WRITE, 10'd16,   11'd16,   1'b1, '{8'hA8, 8'h10, 9'd16,  STATUS_OK,    1'b0, 1'b1}},
    '{CMD_WRITE, 10'd1008, 11'd16,   1'b1, '{8'hAE, 8'hF0, 9'd16,  STATUS_OK,    1'b0, 1'b1}},
    // full-length request on the last byte: clamped to one byte
    '{CMD_WRITE, 10'd1023, 11'd1024, 1'b1, '{8'hAE, 8'hFF, 9'd1,   STATUS_OK,    1'b1, 1'b1}},
    '{CMD_READ,  10'd1023, 11'd1024, 1'b1, '{8'hAE, 8'hFF, 9'd1,   STATUS_OK,    1'b1, 1'b1}},
    // whole chip: the most pages a write can produce, and every block for a read
    '{CMD_WRITE, 10'd0,    11'd1024, 1'b0, '0},
    '{CMD_WRITE, 10'd8,    11'd1024, 1'b0, '0},
    '{CMD_READ,  10'd0,    11'd1024, 1'b0, '0},
    '{CMD_READ,  10'd1,    11'd1024, 1'b0, '0},
    // page and block crossings
    '{CMD_WRITE, 10'd15,   11'd2,    1'b0, '0},
    '{CMD_WRITE, 10'd250,  11'd20,   1'b0, '0},
    '{CMD_READ,  10'd255,  11'd2,    1'b0, '0},
    // length past the chip end
    '{CMD_WRITE, 10'd768,  11'd300,  1'b0, '0},
    '{CMD_WRITE, 10'd1000, 11'd100,  1'b0, '0},
    // alternating bit patterns that end on the second-to-last byte
    '{CMD_READ,  10'h155,  11'h2AA,  1'b0, '0},
    '{CMD_WRITE, 10'h2AA,  11'h155,  1'b0, '0}
  };

  eeprom_transfer_segmenter u_dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .start             (req_start),
    .busy              (req_busy),
    .command_i         (req_cmd),
    .start_address_i   (req_addr),
    .transfer_length_i (req_len),
    .cfg_valid_i       (a2_valid),
    .cfg_ready_o       (a2_ready),
    .cfg_data_i        (a2_data),
    .result_valid_o    (word_strobe),
    .device_select_o   (word_dsel),
    .word_address_o    (word_waddr),
    .segment_length_o  (word_len),
    .status_o          (word_status),
    .truncated_o       (word_trunc),
    .last_segment_o    (word_last)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Control byte in write form: 1010, A2, two block bits, 0
  function automatic logic [7:0] select_byte(int unsigned addr);
    return DEV_BASE | {4'b0, a2_level, 3'b0} | 8'(((addr / BLOCK_BYTES) & 3) << 1);
  endfunction

  // Split one request into the transactions the chip needs and queue them
  function automatic void split_request(logic cmd, logic [ADDR_W-1:0] addr,
                                        logic [LEN_W-1:0] len);
    int unsigned chip;
    int unsigned cur;
    int unsigned rem;
    int unsigned off;
    int unsigned room;
    int unsigned seg;
    int unsigned n;
    int unsigned first;
    logic        trunc;
    xfer_word_t  w;
    chip  = BLOCK_BYTES * BLOCK_COUNT;
    cur   = addr;
    rem   = len;
    n     = 0;
    trunc = 1'b0;
    first = expected_words.size();
    // Empty request or a start past the chip: one rejection word
    if (rem == 0 || cur >= chip) begin
      w.dsel    = select_byte(cur);
      w.waddr   = 8'(cur % BLOCK_BYTES);
      w.seg_len = '0;
      w.status  = STATUS_EMPTY;
      w.trunc   = (rem != 0);
      w.last    = 1'b1;
      expected_words.push_back(w);
      return;
    end
    // Clamp at the chip end
    if (rem > chip - cur) begin
      rem   = chip - cur;
      trunc = 1'b1;
    end
    while (rem > 0 && n < MAX_RESULTS) begin
      off  = cur % BLOCK_BYTES;
      room = BLOCK_BYTES - off;
      if (cmd == CMD_WRITE && PAGE_BYTES - (off % PAGE_BYTES) < room) begin
        room = PAGE_BYTES - (off % PAGE_BYTES);
      end
      seg = (room < rem) ? room : rem;
      rem -= seg;
      w.dsel    = select_byte(cur);
      w.waddr   = 8'(off);
      w.seg_len = SEG_W'(seg);
      w.status  = STATUS_OK;
      w.trunc   = trunc;
      w.last    = (rem == 0 || n == MAX_RESULTS - 1);
      expected_words.push_back(w);
      cur += seg;
      n++;
    end
    // Ran out of transactions: flag every word of this request
    if (rem > 0) begin
      for (int unsigned k = first; k < expected_words.size(); k++) begin
        expected_words[k].trunc = 1'b1;
      end
    end
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 40) begin
      return 0;
    end else if (roll < 85) begin
      return $urandom_range(1, 3);
    end else if (roll < 97) begin
      return $urandom_range(4, 12);
    end else begin
      return $urandom_range(20, 60);
    end
  endfunction

  // Drop start and hold until every queued word has come out and the block is idle.
  // Always advance at least one edge so start is never lowered and raised in one step.
  task automatic drain_block();
    req_start <= 1'b0;
    @(posedge clk);
    while (expected_words.size() != 0 || req_busy) begin
      @(posedge clk);
    end
  endtask

  // Present one request, hold it until accepted, then queue what it should produce.
  // Start stays high on return so a back-to-back request needs no extra edge.
  task automatic issue_request(int unsigned gap, logic cmd, logic [ADDR_W-1:0] addr,
                               logic [LEN_W-1:0] len, logic known, xfer_word_t fixed);
    if (gap > 0) begin
      req_start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_start <= 1'b1;
    req_cmd   <= cmd;
    req_addr  <= addr;
    req_len   <= len;
    @(posedge clk);
    while (req_busy) begin
      @(posedge clk);
    end
    requests_sent++;
    if (known) begin
      expected_words.push_back(fixed);
    end else begin
      split_request(cmd, addr, len);
    end
  endtask

  // Write the A2 level while the block is idle
  task automatic write_a2(logic level);
    drain_block();
    a2_valid <= 1'b1;
    a2_data  <= level;
    @(posedge clk);
    while (!a2_ready) begin
      @(posedge clk);
    end
    a2_level = level;
    a2_writes++;
    a2_valid <= 1'b0;
  endtask

  // Compare every result word against the oldest expectation
  always @(posedge clk) begin : check_words
    xfer_word_t got;
    xfer_word_t want;
    if (rst_n && word_strobe) begin
      got = '{word_dsel, word_waddr, word_len, word_status, word_trunc, word_last};
      words_seen++;
      if (got.status == STATUS_EMPTY) rejected_words++;
      if (got.trunc) truncated_words++;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("%0t: unexpected word ds=%h wa=%h len=%0d st=%b tr=%b last=%b",
                   $realtime, got.dsel, got.waddr, got.seg_len, got.status, got.trunc,
                   got.last);
        end
      end else begin
        want = expected_words.pop_front();
        if (got.dsel !== want.dsel || got.waddr !== want.waddr ||
            got.seg_len !== want.seg_len || got.status !== want.status ||
            got.trunc !== want.trunc || got.last !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("%0t: word mismatch exp ds=%h wa=%h len=%0d st=%b tr=%b last=%b",
                     $realtime, want.dsel, want.waddr, want.seg_len, want.status,
                     want.trunc, want.last);
            $display("%0t:               got ds=%h wa=%h len=%0d st=%b tr=%b last=%b",
                     $realtime, got.dsel, got.waddr, got.seg_len, got.status, got.trunc,
                     got.last);
          end
        end
      end
    end
  end

  // Count cycles in which no handshake of any kind completes
  always @(posedge clk) begin
    if ((req_start && !req_busy) || word_strobe || (a2_valid && a2_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("Timeout: no handshake for %0d cycles, %0d words still expected",
             QUIET_LIMIT, expected_words.size());
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    int unsigned       sel;
    int unsigned       gap;
    logic              cmd;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic              level;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with the A2 level still at its reset value
    foreach (directed_rows[i]) begin
      issue_request(pick_gap(), directed_rows[i].cmd, directed_rows[i].addr,
                    directed_rows[i].len, directed_rows[i].known,
                    directed_rows[i].fixed_word);
    end

    // Random part: each phase runs under its own A2 level, both levels forced first
    for (int unsigned phase = 0; phase < RAND_PHASES; phase++) begin
      level = (phase < 2) ? 1'(phase == 1) : 1'($urandom_range(0, 1));
      write_a2(level);
      for (int unsigned i = 0; i < PHASE_ITEMS; i++) begin
        cmd = 1'($urandom_range(0, 1));
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
          // short transfers anywhere: the bulk of the traffic
          addr = ADDR_W'($urandom_range(0, 1023));
          len  = LEN_W'($urandom_range(1, 40));
        end else if (sel < 65) begin
          addr = ADDR_W'($urandom_range(0, 1023));
          len  = LEN_W'($urandom_range(1, 300));
        end else if (sel < 75) begin
          addr = ADDR_W'($urandom_range(0, 1023));
          len  = LEN_W'($urandom_range(0, 1024));
        end else if (sel < 82) begin
          // near the chip end, mostly clamped
          addr = ADDR_W'(1023 - $urandom_range(0, 40));
          len  = LEN_W'($urandom_range(1, 80));
        end else if (sel < 88) begin
          // around a page start, whole pages
          addr = ADDR_W'(($urandom_range(0, 63) * PAGE_BYTES + 1024 - $urandom_range(0, 1))
                         % 1024);
          len  = LEN_W'($urandom_range(1, 4) * PAGE_BYTES);
        end else if (sel < 93) begin
          addr = ADDR_W'($urandom_range(0, 1023));
          len  = '0;
        end else if (sel < 97) begin
          addr = ADDR_W'($urandom_range(0, 1023));
          len  = LEN_W'(1024);
        end else begin
          // straddle a block boundary
          addr = ADDR_W'(($urandom_range(1, 4) * BLOCK_BYTES - $urandom_range(1, 8)) % 1024);
          len  = LEN_W'($urandom_range(1, 520));
        end
        // Runs of back-to-back requests, otherwise random gaps
        gap = (i % 50 < 12) ? 0 : pick_gap();
        // Now and then hold off until the block has drained completely
        if (i == PHASE_ITEMS / 2 || $urandom_range(0, 99) < 3) begin
          drain_block();
        end
        issue_request(gap, cmd, addr, len, 1'b0, '0);
      end
    end

    // Wait for everything outstanding, then watch for stray words
    drain_block();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d requests (%0d directed), %0d words checked", requests_sent,
             NUM_DIRECTED, words_seen);
    $display("%0d rejected and %0d clamped words, A2 level rewritten %0d times",
             rejected_words, truncated_words, a2_writes);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d bad words, %0d words never seen", mismatches, expected_words.size());
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
